// ----- sv/quadratic_congruential_histogram_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic congruential histogram
// Clocked on clk; the checked form is skipped while rst is high.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_CONGRUENTIAL_HISTOGRAM_MACROS_SVH
`define QUADRATIC_CONGRUENTIAL_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked outside reset.
`define QCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define QCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QCH_ASSERT(lbl, prop, msg)
`define QCH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- sv/qch_pkg.sv -----
// ----------------------------------------------------------------------------
// qch_pkg
// Widths, register indexes and types shared by the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package qch_pkg;

  localparam int VALUE_BITS = 16;
  localparam int BINS       = 10;
  localparam int COUNT_BITS = 32;
  localparam int BIN_BITS   = 4;
  localparam int CFG_BITS   = 3;

  // Effective modulus: zero in the register means 2^VALUE_BITS.
  localparam int MOD_BITS   = VALUE_BITS + 1;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int DSQ_BITS   = 3 * VALUE_BITS;
  localparam int SUM_BITS   = DSQ_BITS + 1;
  localparam int STEP_BITS  = $clog2(SUM_BITS);
  localparam int SCALE_BITS = MOD_BITS + $clog2(BINS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [BIN_BITS-1:0]   bin_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_BITS-1:0]   cfg_idx_t;

  localparam count_t COUNT_MAX = '1;

  // Register indexes
  localparam cfg_idx_t REG_QUAD_COEFF = 3'd0;
  localparam cfg_idx_t REG_LIN_COEFF  = 3'd1;
  localparam cfg_idx_t REG_INCREMENT  = 3'd2;
  localparam cfg_idx_t REG_MODULUS    = 3'd3;
  localparam cfg_idx_t REG_SEED       = 3'd4;

  // Reset values
  localparam value_t RST_QUAD_COEFF = 16'd12;
  localparam value_t RST_LIN_COEFF  = 16'd13;
  localparam value_t RST_INCREMENT  = 16'd35;
  localparam value_t RST_MODULUS    = 16'd1728;
  localparam value_t RST_SEED       = 16'd0;

endpackage

`default_nettype wire

// ----- sv/quadratic_congruential_histogram.sv -----
// Sequence: an accepted input beat passes the multiply, sum, bit-serial remainder,
//   bin scan, memory read and update states before its result beat is loaded.
// Pacing: no new input beat is taken until the previous one has left the update
//   state, after the remainder loop and the single-port memory read-modify-write.
// Reset: registers return to 12, 13, 35, 1728, 0; the value and all bin
//   counts read as zero at once (per-bin valid flags, no clearing pass).
// ----------------------------------------------------------------------------
// quadratic_congruential_histogram
// Quadratic congruential generator x <- (d*x*x + a*x + c) mod m with a
// saturating hit count per decile bin, kept in a small synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_congruential_histogram (
  input  wire                   clk,
  input  wire                   rst,
  // configuration write port
  input  wire                   cfg_write,
  input  wire qch_pkg::cfg_idx_t cfg_index,
  input  wire qch_pkg::value_t  cfg_data,
  // input channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   restart,
  // output channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output qch_pkg::value_t       value,
  output qch_pkg::bin_t         bin,
  output qch_pkg::count_t       bin_count
);

  import qch_pkg::*;

  `include "quadratic_congruential_histogram_macros.svh"

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;  // x*x and a*x
  localparam logic [3:0] ST_MUL2 = 4'd2;  // d*(x*x)
  localparam logic [3:0] ST_SUM  = 4'd3;  // d*x*x + a*x + c
  localparam logic [3:0] ST_DIV  = 4'd4;  // one remainder bit per cycle
  localparam logic [3:0] ST_BINI = 4'd5;  // set up the bin scan
  localparam logic [3:0] ST_BIN  = 4'd6;  // one bin boundary per cycle
  localparam logic [3:0] ST_RD   = 4'd7;  // memory read in flight
  localparam logic [3:0] ST_UPD  = 4'd8;  // increment, write back, emit

  // Configuration registers
  value_t quad_coeff;
  value_t lin_coeff;
  value_t increment;
  value_t modulus;
  value_t seed;

  // Control
  logic [3:0]           state;
  logic [STEP_BITS-1:0] step;
  logic [BINS-1:0]      hit_valid;

  // Datapath
  value_t                current_value;
  logic [PROD_BITS-1:0]  sq;
  logic [PROD_BITS-1:0]  ax;
  logic [DSQ_BITS-1:0]   dsq;
  logic [SUM_BITS-1:0]   dividend;
  value_t                rem;
  logic [SCALE_BITS-1:0] tx_scaled;
  logic [SCALE_BITS-1:0] bound;
  bin_t                  bin_idx;

  // Histogram memory
  count_t hist_mem [BINS];
  count_t rd_data;

  logic                  in_fire;
  logic [MOD_BITS-1:0]   mm;
  logic [MOD_BITS-1:0]   rem_sh;
  logic                  bin_hit;
  logic                  rd_en;
  logic                  emit;
  count_t                cnt_old;
  count_t                cnt_next;

  // Zero in the modulus register wraps at the full register width.
  assign mm = {(modulus == '0), modulus};

  assign in_stall = rst || (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign rem_sh  = {rem, dividend[SUM_BITS-1]};
  assign bin_hit = (tx_scaled <= bound) || (bin_idx == BIN_BITS'(BINS - 1));
  assign rd_en   = (state == ST_BIN) && bin_hit;

  // Hold the finished count until the output register is free.
  assign emit = (state == ST_UPD) && (!out_valid || !out_stall);

  // A bin not touched since the last clear reads as zero; stop at the maximum.
  assign cnt_old  = hit_valid[bin_idx] ? rd_data : '0;
  assign cnt_next = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_coeff <= RST_QUAD_COEFF;
      lin_coeff  <= RST_LIN_COEFF;
      increment  <= RST_INCREMENT;
      modulus    <= RST_MODULUS;
      seed       <= RST_SEED;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUAD_COEFF: quad_coeff <= cfg_data;
        REG_LIN_COEFF:  lin_coeff  <= cfg_data;
        REG_INCREMENT:  increment  <= cfg_data;
        REG_MODULUS:    modulus    <= cfg_data;
        REG_SEED:       seed       <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      hit_valid     <= '0;
      current_value <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Load a new result beat, or retire the waiting one once taken.
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            // Restart: reload the seed, and invalidate every bin at once.
            if (restart) begin
              current_value <= seed;
              hit_valid     <= '0;
            end
            state <= ST_MUL1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_SUM;
        ST_SUM: begin
          step  <= STEP_BITS'(SUM_BITS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_BINI;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_BINI: state <= ST_BIN;
        ST_BIN: begin
          if (bin_hit) begin
            state <= ST_RD;
          end
        end
        ST_RD: state <= ST_UPD;
        ST_UPD: begin
          if (emit) begin
            hit_valid[bin_idx] <= 1'b1;
            current_value      <= rem;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic datapath (no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL1: begin
        sq <= PROD_BITS'(current_value) * PROD_BITS'(current_value);
        ax <= PROD_BITS'(lin_coeff) * PROD_BITS'(current_value);
      end
      ST_MUL2: begin
        dsq <= DSQ_BITS'(quad_coeff) * DSQ_BITS'(sq);
      end
      ST_SUM: begin
        dividend <= SUM_BITS'(dsq) + SUM_BITS'(ax) + SUM_BITS'(increment);
        rem      <= '0;
      end
      ST_DIV: begin
        // Restoring remainder: shift in one dividend bit, subtract if it fits.
        if (rem_sh >= mm) begin
          rem <= VALUE_BITS'(rem_sh - mm);
        end else begin
          rem <= rem_sh[VALUE_BITS-1:0];
        end
        dividend <= dividend << 1;
      end
      ST_BINI: begin
        tx_scaled <= SCALE_BITS'(rem) * SCALE_BITS'(BINS);
        bound     <= SCALE_BITS'(mm);
        bin_idx   <= '0;
      end
      ST_BIN: begin
        // Advance to the next boundary j*m until BINS*x fits under it.
        if (!bin_hit) begin
          bound   <= bound + SCALE_BITS'(mm);
          bin_idx <= bin_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      value     <= rem;
      bin       <= bin_idx;
      bin_count <= cnt_next;
    end
  end

  // --------------------------------------------------------------------------
  // Histogram memory: one port, registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= hist_mem[bin_idx];
    end
    if (emit) begin
      hist_mem[bin_idx] <= cnt_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `QCH_ASSERT(a_rem_below_mod, (state == ST_DIV) |-> ({1'b0, rem} < mm), "remainder reached modulus")
  `QCH_ASSERT(a_out_in_range, out_valid |-> (bin <= BIN_BITS'(BINS - 1)) && ({1'b0, value} < mm), "result out of range")
  `QCH_ASSERT(a_count_nonzero, $rose(out_valid) |-> (bin_count != '0), "emitted a zero bin count")
  `QCH_ASSERT_ALWAYS(a_idle_after_reset, rst |=> (state == ST_IDLE) && !out_valid, "busy after reset")

endmodule

`default_nettype wire

// ----- bench/quadratic_congruential_histogram_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_congruential_histogram_tb
// Self-checking bench for the quadratic congruential generator and its decile
// histogram. A scoreboard class keeps its own copy of the registers, the
// generator value and the bin counts. From these it works out each result beat
// when the input beat is taken, and compares it field by field with what the
// block returns. Plain tasks drive the write port and the input channel. A
// receiver process stalls the output at random and also holds it off for one
// long stretch. A short directed run covers the register extremes: modulus zero
// and one, a seed and coefficients at or above the modulus, a value that lands
// exactly on a bin edge, and unused register indexes. Random phases follow,
// each with its own register setting and idling mix.
// ----------------------------------------------------------------------------
module quadratic_congruential_histogram_tb;
  import qch_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int HOLD_CYCLES   = 600;  // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 80;   // longer than the block's latency
  localparam int DRAIN_CYCLES  = 8;    // let the histogram write land before a write
  localparam int MAX_GAP       = 130;  // sender gap, about two item times
  localparam int PHASE_ITEMS   = 225;
  localparam int PHASES        = 8;
  localparam int RESTART_PCT   = 5;
  localparam int PRINT_LIMIT   = 40;

  // One expected result beat
  typedef struct packed {
    value_t value;
    bin_t   bin;
    count_t count;
  } draw_t;

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, generator state and the queue of expected draws
  // --------------------------------------------------------------------------
  class draw_scoreboard;
    value_t quad, lin, incr, modulus, seed;
    value_t cur;
    count_t hist[BINS];
    draw_t  pending[$];
    int     mismatches;
    int     checked;
    int     restarts;

    function new();
      quad    = RST_QUAD_COEFF;
      lin     = RST_LIN_COEFF;
      incr    = RST_INCREMENT;
      modulus = RST_MODULUS;
      seed    = RST_SEED;
      cur     = '0;
      foreach (hist[k]) hist[k] = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, value_t data);
      case (idx)
        REG_QUAD_COEFF: quad    = data;
        REG_LIN_COEFF:  lin     = data;
        REG_INCREMENT:  incr    = data;
        REG_MODULUS:    modulus = data;
        REG_SEED:       seed    = data;
        default: ;
      endcase
    endfunction

    // Advance the generator for one accepted input beat and queue the result.
    function void note_step(bit restart_bit);
      longint unsigned span, x, t;
      int slot;
      draw_t draw;
      // A zero modulus wraps at the register width.
      span = (modulus == '0) ? (64'd1 << VALUE_BITS) : 64'(modulus);
      if (restart_bit) begin
        cur = seed;
        foreach (hist[k]) hist[k] = '0;
        restarts++;
      end
      x = cur % span;
      t = ((quad % span) * ((x * x) % span)) % span;
      t = (t + ((lin % span) * x) % span) % span;
      t = (t + incr % span) % span;
      cur = value_t'(t);
      // Smallest j with BINS*t <= j*span; scan downward so the last hit wins.
      slot = BINS - 1;
      for (int j = BINS; j >= 1; j--) begin
        if (BINS * t <= j * span) slot = j - 1;
      end
      if (hist[slot] != COUNT_MAX) hist[slot]++;
      draw.value = value_t'(t);
      draw.bin   = bin_t'(slot);
      draw.count = hist[slot];
      pending.push_back(draw);
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_draw(value_t got_value, bin_t got_bin, count_t got_count);
      draw_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat with nothing expected: value %0d bin %0d count %0d",
                         got_value, got_bin, got_count));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got_value !== want.value)
        report($sformatf("draw %0d value %0d, predicted %0d", checked, got_value, want.value));
      if (got_bin !== want.bin)
        report($sformatf("draw %0d bin %0d, predicted %0d", checked, got_bin, want.bin));
      if (got_count !== want.count)
        report($sformatf("draw %0d bin_count %0d, predicted %0d",
                         checked, got_count, want.count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs: every input known from time zero
  // --------------------------------------------------------------------------
  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cfg_write = 1'b0;
  cfg_idx_t cfg_index = '0;
  value_t   cfg_data  = '0;
  logic     in_valid  = 1'b0;
  logic     restart   = 1'b0;
  logic     out_stall = 1'b0;

  logic     in_stall;
  logic     out_valid;
  value_t   value;
  bin_t     bin;
  count_t   bin_count;

  draw_scoreboard model = new();

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;  // bumped by the stimulus only
  int hold_served    = 0;  // owned by the receiver process
  int hold_left      = 0;
  int settings_used  = 0;

  always #2 clk = ~clk;

  quadratic_congruential_histogram i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .bin       (bin),
    .bin_count (bin_count)
  );

  // --------------------------------------------------------------------------
  // Receiver: check each result beat, then pick next cycle's stall.
  // Values read here are the ones the edge itself saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) model.check_draw(value, bin, bin_count);
    // Start a long hold-off when the stimulus asks for one.
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  function automatic void set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 82; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 82; end
      IDLE_BOTH:     begin send_gap_pct = 11; recv_stall_pct = 11; end
      default: ;
    endcase
  endfunction

  // Offer one input beat and hold it until the block takes it. Valid stays high
  // on return, so back-to-back beats never drop it for a cycle.
  task automatic send_beat(input bit restart_bit);
    int gap;
    if ($urandom_range(99) < send_gap_pct) begin
      // Gaps of up to two item times land on every phase of the block's work.
      gap = $urandom_range(1, MAX_GAP);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    do @(posedge clk); while (in_stall);
    model.note_step(restart_bit);
  endtask

  // Wait until every expected result beat has come back.
  task automatic wait_drained();
    while (model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input value_t data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model.set_reg(idx, data);
  endtask

  // Write all five registers, plus one random unused index, which the block
  // drops.
  task automatic apply_setting(input value_t d, input value_t a, input value_t c,
                               input value_t m, input value_t s);
    write_reg(REG_QUAD_COEFF, d);
    write_reg(REG_LIN_COEFF,  a);
    write_reg(REG_INCREMENT,  c);
    write_reg(REG_MODULUS,    m);
    write_reg(REG_SEED,       s);
    write_reg(cfg_idx_t'($urandom_range(int'(REG_SEED) + 1, (1 << CFG_BITS) - 1)),
              value_t'($urandom));
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // A few beats with a fixed restart pattern, bit i for beat i.
  task automatic run_directed(input int n, input bit [7:0] restarts);
    for (int i = 0; i < n; i++) send_beat(restarts[i]);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Random setting: mostly full-range values, with some small moduli, a zero
  // or one modulus now and then, and seeds at or above the modulus.
  task automatic random_setting();
    value_t d, a, c, m, s;
    case ($urandom_range(7))
      0:       m = '0;
      1:       m = value_t'(1);
      2:       m = value_t'($urandom_range(2, 40));
      3:       m = '1;
      default: m = value_t'($urandom);
    endcase
    d = ($urandom_range(7) == 0) ? '0 : value_t'($urandom);
    a = ($urandom_range(7) == 0) ? '0 : value_t'($urandom);
    c = ($urandom_range(7) == 0) ? '0 : value_t'($urandom);
    if ($urandom_range(3) == 0 || m == '0) s = value_t'($urandom);
    else s = value_t'($urandom % m);
    apply_setting(d, a, c, m, s);
  endtask

  // Long runs of ordinary steps with the odd restart; optionally start the
  // long receiver hold-off a third of the way in while beats keep coming.
  task automatic random_phase(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_requests++;
      send_beat($urandom_range(99) < RESTART_PCT);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // Reset registers: step from zero, then restart and step again.
    run_directed(4, 8'b0000_0100);
    // Modulus zero wraps at 2^16; all ones everywhere else.
    apply_setting('1, '1, '1, '0, '1);
    run_directed(3, 8'b0000_0001);
    // Modulus one: every value is zero, always bin 0.
    apply_setting(value_t'(5), value_t'(7), value_t'(3), value_t'(1), value_t'(9));
    run_directed(3, 8'b0000_0010);
    // Seed and coefficients far above a modulus of two.
    apply_setting(value_t'(1000), value_t'(2000), value_t'(3000), value_t'(2),
                  value_t'(12345));
    run_directed(3, 8'b0000_0001);
    // x stays at 10 with modulus 20: exactly on the edge of bin 4.
    apply_setting('0, value_t'(1), '0, value_t'(20), value_t'(10));
    run_directed(2, 8'b0000_0001);
    // Largest nonzero modulus, seed just below it.
    apply_setting('1, '0, value_t'(16'hFFFE), '1, value_t'(16'hFFFE));
    run_directed(3, 8'b0000_0001);

    // Random phases; each drains fully before the next setting is written.
    for (int p = 0; p < PHASES; p++) begin
      random_setting();
      set_idling(idle_mode_t'(p % 4));
      random_phase(PHASE_ITEMS, p == 2);
    end

    // Allow for any stray result beat after the last one expected.
    set_idling(IDLE_NONE);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.pending.size() != 0)
      model.report($sformatf("%0d expected draws never arrived", model.pending.size()));

    $display("summary: %0d draws checked over %0d register settings, %0d restarts",
             model.checked, settings_used + 1, model.restarts);
    $display("summary: modulus zero and one, bin edge, idle mixes and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (model.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("watchdog expired with %0d draws outstanding", model.pending.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- quadratic_congruential_histogram.f -----
+incdir+sv
sv/qch_pkg.sv
sv/quadratic_congruential_histogram.sv
bench/quadratic_congruential_histogram_tb.sv
